// ----- design/bsm_pkg.sv -----
// shared types, opcodes, status codes and defaults for the byte stack machine core
package bsm_pkg;

    // default sizes of the stack
    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_WIDTH_DEF  = 8;

    // fixed field widths
    localparam int ACTION_W  = 4;
    localparam int OPERAND_W = 8;
    localparam int STATUS_W  = 3;
    localparam int IP_W      = 8;
    localparam int PLEN_W    = 9;
    localparam int DEPTH_W   = 7;
    localparam int CHAR_W    = 8;

    localparam logic [PLEN_W-1:0] PLEN_RESET = 9'd256;

    // opcodes
    localparam logic [ACTION_W-1:0] OP_PUSH  = 4'd0;
    localparam logic [ACTION_W-1:0] OP_ADD   = 4'd1;
    localparam logic [ACTION_W-1:0] OP_SUB   = 4'd2;
    localparam logic [ACTION_W-1:0] OP_GT    = 4'd3;
    localparam logic [ACTION_W-1:0] OP_LT    = 4'd4;
    localparam logic [ACTION_W-1:0] OP_JMP   = 4'd5;
    localparam logic [ACTION_W-1:0] OP_JNZ   = 4'd6;
    localparam logic [ACTION_W-1:0] OP_JZ    = 4'd7;
    localparam logic [ACTION_W-1:0] OP_DUP   = 4'd8;
    localparam logic [ACTION_W-1:0] OP_POP   = 4'd9;
    localparam logic [ACTION_W-1:0] OP_HALT  = 4'd10;
    localparam logic [ACTION_W-1:0] OP_WRITE = 4'd11;
    localparam logic [ACTION_W-1:0] OP_SWAP  = 4'd12;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_JUMP   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_OPERAND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_OPCODE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_HALTED     = 3'd6;

    // control outcome of one executed instruction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wr_en;
        logic                char_valid;
        logic                halted;
    } bsm_ctrl_t;

endpackage

// ----- design/bsm_ram.sv -----
// generic RAM with one write port and two registered read ports
module bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and read-before-write registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- design/bsm_exec.sv -----
// execute unit: next stack, pointer and flag values for one instruction
module bsm_exec #(
    parameter int STACK_DEPTH = bsm_pkg::STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = bsm_pkg::WORD_WIDTH_DEF,
    localparam int SPW  = $clog2(STACK_DEPTH + 1),
    localparam int AW   = $clog2(STACK_DEPTH),
    localparam int CMPW = (SPW > bsm_pkg::OPERAND_W) ? SPW : bsm_pkg::OPERAND_W
) (
    input  logic [bsm_pkg::ACTION_W-1:0]  action,
    input  logic [bsm_pkg::OPERAND_W-1:0] operand,
    input  logic [SPW-1:0]                sp,
    input  logic [bsm_pkg::IP_W-1:0]      ip,
    input  logic                          halted,
    input  logic [bsm_pkg::PLEN_W-1:0]    program_length,
    input  logic [WORD_WIDTH-1:0]         top,
    input  logic [WORD_WIDTH-1:0]         second,
    input  logic [WORD_WIDTH-1:0]         deep,
    input  logic [AW-1:0]                 deep_addr,
    output bsm_pkg::bsm_ctrl_t            ctrl,
    output logic [SPW-1:0]                sp_next,
    output logic [bsm_pkg::IP_W-1:0]      ip_next,
    output logic [WORD_WIDTH-1:0]         top_next,
    output logic [AW-1:0]                 wr_addr,
    output logic [bsm_pkg::CHAR_W-1:0]    char_out
);

    logic            jumped;
    logic            jump_bad;
    logic            arg_ge_sp;
    logic            sp_full;
    logic            sp_lt1;
    logic            sp_lt2;
    logic            top_nz;
    logic            take;
    logic [AW-1:0]   push_addr;

    // shared compares
    assign jump_bad  = {1'b0, operand} >= program_length;
    assign arg_ge_sp = CMPW'(operand) >= CMPW'(sp);
    assign sp_full   = sp >= SPW'(STACK_DEPTH);
    assign sp_lt1    = sp == '0;
    assign sp_lt2    = sp < SPW'(2);
    assign top_nz    = top != '0;
    assign take      = (action == bsm_pkg::OP_JNZ) == top_nz;
    assign push_addr = AW'(sp - SPW'(1));

    // instruction decode and execute
    always_comb
    begin
        ctrl            = '0;
        ctrl.status     = bsm_pkg::ST_OK;
        ctrl.halted     = halted;
        sp_next         = sp;
        top_next        = top;
        wr_addr         = push_addr;
        char_out        = '0;
        jumped          = 1'b0;
        if (halted)
        begin
            ctrl.status = bsm_pkg::ST_HALTED;
        end
        else
        begin
            case (action)
                bsm_pkg::OP_PUSH:
                begin
                    if (sp_full)
                    begin
                        ctrl.status = bsm_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        // old top spills into the RAM below the new top
                        ctrl.wr_en = !sp_lt1;
                        top_next   = WORD_WIDTH'(operand);
                        sp_next    = sp + SPW'(1);
                    end
                end
                bsm_pkg::OP_ADD, bsm_pkg::OP_SUB, bsm_pkg::OP_GT, bsm_pkg::OP_LT:
                begin
                    if (sp_lt2)
                    begin
                        ctrl.status = bsm_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        case (action)
                            bsm_pkg::OP_ADD: top_next = second + top;
                            bsm_pkg::OP_SUB: top_next = second - top;
                            bsm_pkg::OP_GT:  top_next = WORD_WIDTH'(second > top);
                            default:         top_next = WORD_WIDTH'(second < top);
                        endcase
                        sp_next = sp - SPW'(1);
                    end
                end
                bsm_pkg::OP_JMP:
                begin
                    if (jump_bad)
                    begin
                        ctrl.status = bsm_pkg::ST_BAD_JUMP;
                    end
                    else
                    begin
                        jumped = 1'b1;
                    end
                end
                bsm_pkg::OP_JNZ, bsm_pkg::OP_JZ:
                begin
                    if (jump_bad)
                    begin
                        ctrl.status = bsm_pkg::ST_BAD_JUMP;
                    end
                    else if (sp_lt1)
                    begin
                        ctrl.status = bsm_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        jumped = take;
                    end
                end
                bsm_pkg::OP_DUP:
                begin
                    if (arg_ge_sp)
                    begin
                        ctrl.status = bsm_pkg::ST_BAD_OPERAND;
                    end
                    else if (sp_full)
                    begin
                        ctrl.status = bsm_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        // copy of the top itself, or of a deeper RAM entry
                        ctrl.wr_en = 1'b1;
                        top_next   = (operand == '0) ? top : deep;
                        sp_next    = sp + SPW'(1);
                    end
                end
                bsm_pkg::OP_POP:
                begin
                    if (sp_lt1)
                    begin
                        ctrl.status = bsm_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        top_next = second;
                        sp_next  = sp - SPW'(1);
                    end
                end
                bsm_pkg::OP_HALT:
                begin
                    ctrl.halted = 1'b1;
                end
                bsm_pkg::OP_WRITE:
                begin
                    if (sp_lt1)
                    begin
                        ctrl.status = bsm_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctrl.char_valid = 1'b1;
                        char_out        = top[bsm_pkg::CHAR_W-1:0];
                    end
                end
                bsm_pkg::OP_SWAP:
                begin
                    if (sp_lt1 || arg_ge_sp)
                    begin
                        ctrl.status = bsm_pkg::ST_BAD_OPERAND;
                    end
                    else if (operand != '0)
                    begin
                        // deep entry comes up, old top goes down in its place
                        ctrl.wr_en = 1'b1;
                        wr_addr    = deep_addr;
                        top_next   = deep;
                    end
                end
                default:
                begin
                    ctrl.status = bsm_pkg::ST_BAD_OPCODE;
                end
            endcase
        end
    end

    // instruction pointer: hold on error, load on taken jump, else advance
    always_comb
    begin
        if (ctrl.status != bsm_pkg::ST_OK)
        begin
            ip_next = ip;
        end
        else if (jumped)
        begin
            ip_next = operand;
        end
        else
        begin
            ip_next = ip + bsm_pkg::IP_W'(1);
        end
    end

endmodule

// ----- design/byte_stack_machine_execute_core.sv -----
// top level of the byte stack machine execute core
// One instruction is taken per clock whenever start is high (busy stays low),
// and its result appears on the result ports for one cycle, marked by
// result_valid; the receiver cannot stall it. The instruction passes the
// instruction register and the registered reads of the stack RAM, then the
// execute logic and the result register. The top of stack lives in a register
// and the entries below it in a RAM with two read ports and one write port.
// program_length is written through the cfg port; the user must write it only
// while no instruction is in flight, as the core does not enforce it.
module byte_stack_machine_execute_core #(
    parameter int STACK_DEPTH = bsm_pkg::STACK_DEPTH_DEF,
    parameter int WORD_WIDTH  = bsm_pkg::WORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bsm_pkg::ACTION_W-1:0]  action,
    input  logic [bsm_pkg::OPERAND_W-1:0] operand,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsm_pkg::PLEN_W-1:0]    cfg_data,
    output logic                          result_valid,
    output logic [bsm_pkg::STATUS_W-1:0]  status,
    output logic [bsm_pkg::IP_W-1:0]      next_ip,
    output logic                          is_halted,
    output logic                          char_valid,
    output logic [bsm_pkg::CHAR_W-1:0]    char_out,
    output logic [bsm_pkg::DEPTH_W-1:0]   stack_depth
);

    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int CMPW = (SPW > bsm_pkg::OPERAND_W) ? SPW : bsm_pkg::OPERAND_W;

    // architectural state
    logic [SPW-1:0]                sp_reg;
    logic [bsm_pkg::IP_W-1:0]      ip_reg;
    logic                          halted_reg;
    logic [bsm_pkg::PLEN_W-1:0]    plen_reg;
    logic [WORD_WIDTH-1:0]         top_reg;

    // instruction register
    logic                          exe_valid_reg;
    logic [bsm_pkg::ACTION_W-1:0]  action_reg;
    logic [bsm_pkg::OPERAND_W-1:0] operand_reg;
    logic [AW-1:0]                 raddr_a_reg;
    logic [AW-1:0]                 raddr_b_reg;

    // write bypass
    logic                          byp_valid_reg;
    logic [AW-1:0]                 byp_addr_reg;
    logic [WORD_WIDTH-1:0]         byp_data_reg;

    // result register
    logic                          result_valid_reg;
    logic [bsm_pkg::STATUS_W-1:0]  status_reg;
    logic [bsm_pkg::IP_W-1:0]      next_ip_reg;
    logic                          is_halted_reg;
    logic                          char_valid_reg;
    logic [bsm_pkg::CHAR_W-1:0]    char_out_reg;
    logic [bsm_pkg::DEPTH_W-1:0]   stack_depth_reg;

    logic                          accept;
    logic [SPW-1:0]                sp_src;
    logic [AW-1:0]                 raddr_a;
    logic [AW-1:0]                 raddr_b;
    logic [WORD_WIDTH-1:0]         rdata_a;
    logic [WORD_WIDTH-1:0]         rdata_b;
    logic [WORD_WIDTH-1:0]         second;
    logic [WORD_WIDTH-1:0]         deep;
    logic                          mem_we;

    bsm_pkg::bsm_ctrl_t            ctrl;
    logic [SPW-1:0]                sp_next;
    logic [bsm_pkg::IP_W-1:0]      ip_next;
    logic [WORD_WIDTH-1:0]         top_next;
    logic [AW-1:0]                 wr_addr;
    logic [bsm_pkg::CHAR_W-1:0]    char_next;

    // handshakes: one instruction per cycle, config always taken
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // read addresses use the stack pointer left by the instruction in execute
    assign sp_src  = exe_valid_reg ? sp_next : sp_reg;
    assign raddr_a = AW'(sp_src - SPW'(2));
    assign raddr_b = AW'(CMPW'(sp_src) - CMPW'(1) - CMPW'(operand));

    // forward the write made in the same cycle as the read
    assign second = (byp_valid_reg && byp_addr_reg == raddr_a_reg) ? byp_data_reg : rdata_a;
    assign deep   = (byp_valid_reg && byp_addr_reg == raddr_b_reg) ? byp_data_reg : rdata_b;

    assign mem_we = exe_valid_reg && ctrl.wr_en;

    bsm_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (wr_addr),
        .wdata   (top_reg),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    bsm_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_exec (
        .action         (action_reg),
        .operand        (operand_reg),
        .sp             (sp_reg),
        .ip             (ip_reg),
        .halted         (halted_reg),
        .program_length (plen_reg),
        .top            (top_reg),
        .second         (second),
        .deep           (deep),
        .deep_addr      (raddr_b_reg),
        .ctrl           (ctrl),
        .sp_next        (sp_next),
        .ip_next        (ip_next),
        .top_next       (top_next),
        .wr_addr        (wr_addr),
        .char_out       (char_next)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exe_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            byp_valid_reg    <= 1'b0;
            sp_reg           <= '0;
            ip_reg           <= '0;
            halted_reg       <= 1'b0;
            plen_reg         <= bsm_pkg::PLEN_RESET;
        end
        else
        begin
            exe_valid_reg    <= accept;
            result_valid_reg <= exe_valid_reg;
            if (cfg_valid && cfg_ready)
            begin
                plen_reg <= cfg_data;
            end
            if (exe_valid_reg)
            begin
                sp_reg     <= sp_next;
                ip_reg     <= ip_next;
                halted_reg <= ctrl.halted;
            end
            if (mem_we)
            begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg  <= action;
            operand_reg <= operand;
            raddr_a_reg <= raddr_a;
            raddr_b_reg <= raddr_b;
        end
        if (mem_we)
        begin
            byp_addr_reg <= wr_addr;
            byp_data_reg <= top_reg;
        end
        if (exe_valid_reg)
        begin
            top_reg         <= top_next;
            status_reg      <= ctrl.status;
            next_ip_reg     <= ip_next;
            is_halted_reg   <= ctrl.halted;
            char_valid_reg  <= ctrl.char_valid;
            char_out_reg    <= char_next;
            stack_depth_reg <= bsm_pkg::DEPTH_W'(sp_next);
        end
    end

    // result ports
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign next_ip      = next_ip_reg;
    assign is_halted    = is_halted_reg;
    assign char_valid   = char_valid_reg;
    assign char_out     = char_out_reg;
    assign stack_depth  = stack_depth_reg;

    // stack pointer never passes the stack size
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack size");

    // every accepted instruction gives a result on result_valid
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 result_valid)
        else $error("result missing two cycles after start");

    // a halted machine stays halted
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared");

    // an error leaves the pointers unchanged
    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (exe_valid_reg && ctrl.status != bsm_pkg::ST_OK) |=> ($stable(sp_reg) && $stable(ip_reg)))
        else $error("state changed on error");

    // the stack RAM is written only by a successful instruction
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ctrl.status == bsm_pkg::ST_OK)
        else $error("stack write on error");

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the byte stack machine execute core
`timescale 1ns / 1ps

module tb;

    // opcodes the core does not decode
    localparam logic [bsm_pkg::ACTION_W-1:0] OP_ILLEGAL_LO = 4'd13;
    localparam logic [bsm_pkg::ACTION_W-1:0] OP_ILLEGAL_HI = 4'd15;

    localparam int NUM_DIRECTED = 26;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 128;
    localparam int REPORT_MAX   = 10;

    // one result transaction as seen on the result ports
    typedef struct packed {
        logic [bsm_pkg::STATUS_W-1:0] status;
        logic [bsm_pkg::IP_W-1:0]     next_ip;
        logic                         is_halted;
        logic                         char_valid;
        logic [bsm_pkg::CHAR_W-1:0]   char_out;
        logic [bsm_pkg::DEPTH_W-1:0]  stack_depth;
    } outcome_t;

    // one row of the directed program
    typedef struct packed {
        logic [bsm_pkg::ACTION_W-1:0]  act;
        logic [bsm_pkg::OPERAND_W-1:0] opd;
        logic                          typed;
        outcome_t                      exp;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [bsm_pkg::ACTION_W-1:0]  action;
    logic [bsm_pkg::OPERAND_W-1:0] operand;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [bsm_pkg::PLEN_W-1:0]    cfg_data;
    logic                          result_valid;
    logic [bsm_pkg::STATUS_W-1:0]  status;
    logic [bsm_pkg::IP_W-1:0]      next_ip;
    logic                          is_halted;
    logic                          char_valid;
    logic [bsm_pkg::CHAR_W-1:0]    char_out;
    logic [bsm_pkg::DEPTH_W-1:0]   stack_depth;

    // shadow copy of the machine state
    logic [bsm_pkg::WORD_WIDTH_DEF-1:0] shadow_stack [bsm_pkg::STACK_DEPTH_DEF];
    int                                 shadow_sp     = 0;
    logic [bsm_pkg::IP_W-1:0]           shadow_ip     = '0;
    logic                               shadow_halted = 1'b0;
    logic [bsm_pkg::PLEN_W-1:0]         shadow_plen   = bsm_pkg::PLEN_RESET;

    outcome_t pending_outcomes [$];
    outcome_t seen_outcome;
    outcome_t due_outcome;
    int       mismatch_count = 0;

    // directed program, run with program_length at 200
    dir_row_t directed_prog [NUM_DIRECTED] = '{
        '{bsm_pkg::OP_POP,   8'd0,   1'b1,
          '{bsm_pkg::ST_UNDERFLOW,   8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{bsm_pkg::OP_ADD,   8'd0,   1'b1,
          '{bsm_pkg::ST_UNDERFLOW,   8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{bsm_pkg::OP_WRITE, 8'd0,   1'b1,
          '{bsm_pkg::ST_UNDERFLOW,   8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{bsm_pkg::OP_JNZ,   8'd255, 1'b1,
          '{bsm_pkg::ST_BAD_JUMP,    8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{bsm_pkg::OP_JZ,    8'd10,  1'b1,
          '{bsm_pkg::ST_UNDERFLOW,   8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{bsm_pkg::OP_DUP,   8'd0,   1'b1,
          '{bsm_pkg::ST_BAD_OPERAND, 8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{bsm_pkg::OP_SWAP,  8'd0,   1'b1,
          '{bsm_pkg::ST_BAD_OPERAND, 8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{OP_ILLEGAL_LO,     8'd0,   1'b1,
          '{bsm_pkg::ST_BAD_OPCODE,  8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{OP_ILLEGAL_HI,     8'd255, 1'b1,
          '{bsm_pkg::ST_BAD_OPCODE,  8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{bsm_pkg::OP_JMP,   8'd200, 1'b1,
          '{bsm_pkg::ST_BAD_JUMP,    8'd0, 1'b0, 1'b0, 8'd0, 7'd0}},
        '{bsm_pkg::OP_PUSH,  8'd255, 1'b1,
          '{bsm_pkg::ST_OK,          8'd1, 1'b0, 1'b0, 8'd0, 7'd1}},
        '{bsm_pkg::OP_PUSH,  8'd1,   1'b1,
          '{bsm_pkg::ST_OK,          8'd2, 1'b0, 1'b0, 8'd0, 7'd2}},
        '{bsm_pkg::OP_ADD,   8'd0,   1'b0, '0},
        '{bsm_pkg::OP_WRITE, 8'd0,   1'b0, '0},
        '{bsm_pkg::OP_PUSH,  8'd1,   1'b0, '0},
        '{bsm_pkg::OP_SUB,   8'd0,   1'b0, '0},
        '{bsm_pkg::OP_PUSH,  8'd7,   1'b0, '0},
        '{bsm_pkg::OP_GT,    8'd0,   1'b0, '0},
        '{bsm_pkg::OP_PUSH,  8'd9,   1'b0, '0},
        '{bsm_pkg::OP_LT,    8'd0,   1'b0, '0},
        '{bsm_pkg::OP_DUP,   8'd0,   1'b0, '0},
        '{bsm_pkg::OP_PUSH,  8'd42,  1'b0, '0},
        '{bsm_pkg::OP_SWAP,  8'd2,   1'b0, '0},
        '{bsm_pkg::OP_JNZ,   8'd199, 1'b0, '0},
        '{bsm_pkg::OP_JZ,    8'd3,   1'b0, '0},
        '{bsm_pkg::OP_JMP,   8'd0,   1'b0, '0}
    };

    byte_stack_machine_execute_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .operand      (operand),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .next_ip      (next_ip),
        .is_halted    (is_halted),
        .char_valid   (char_valid),
        .char_out     (char_out),
        .stack_depth  (stack_depth)
    );

    always #6 clk = ~clk;

    // execute one instruction on the shadow state and return its outcome
    function automatic outcome_t execute_instr(input logic [bsm_pkg::ACTION_W-1:0]  act,
                                               input logic [bsm_pkg::OPERAND_W-1:0] opd);
        outcome_t                           res;
        logic [bsm_pkg::WORD_WIDTH_DEF-1:0] lhs;
        logic [bsm_pkg::WORD_WIDTH_DEF-1:0] rhs;
        logic [bsm_pkg::WORD_WIDTH_DEF-1:0] tmp;
        logic                               jumped;
        int                                 sp;
        res        = '0;
        res.status = bsm_pkg::ST_OK;
        jumped     = 1'b0;
        sp         = shadow_sp;
        if (shadow_halted)
        begin
            res.status = bsm_pkg::ST_HALTED;
        end
        else
        begin
            case (act)
                bsm_pkg::OP_PUSH:
                begin
                    if (sp >= bsm_pkg::STACK_DEPTH_DEF)
                        res.status = bsm_pkg::ST_OVERFLOW;
                    else
                    begin
                        shadow_stack[sp] = opd;
                        shadow_sp        = sp + 1;
                    end
                end
                bsm_pkg::OP_ADD, bsm_pkg::OP_SUB, bsm_pkg::OP_GT, bsm_pkg::OP_LT:
                begin
                    if (sp < 2)
                        res.status = bsm_pkg::ST_UNDERFLOW;
                    else
                    begin
                        lhs = shadow_stack[sp-2];
                        rhs = shadow_stack[sp-1];
                        case (act)
                            bsm_pkg::OP_ADD: tmp = lhs + rhs;
                            bsm_pkg::OP_SUB: tmp = lhs - rhs;
                            bsm_pkg::OP_GT:  tmp = (lhs > rhs) ? 8'd1 : 8'd0;
                            default:         tmp = (lhs < rhs) ? 8'd1 : 8'd0;
                        endcase
                        shadow_stack[sp-2] = tmp;
                        shadow_sp          = sp - 1;
                    end
                end
                bsm_pkg::OP_JMP:
                begin
                    if ({1'b0, opd} >= shadow_plen)
                        res.status = bsm_pkg::ST_BAD_JUMP;
                    else
                    begin
                        shadow_ip = opd;
                        jumped    = 1'b1;
                    end
                end
                bsm_pkg::OP_JNZ, bsm_pkg::OP_JZ:
                begin
                    // target is checked ahead of the stack
                    if ({1'b0, opd} >= shadow_plen)
                        res.status = bsm_pkg::ST_BAD_JUMP;
                    else if (sp < 1)
                        res.status = bsm_pkg::ST_UNDERFLOW;
                    else if ((act == bsm_pkg::OP_JNZ) == (shadow_stack[sp-1] != '0))
                    begin
                        shadow_ip = opd;
                        jumped    = 1'b1;
                    end
                end
                bsm_pkg::OP_DUP:
                begin
                    // depth is checked ahead of overflow
                    if (int'(opd) >= sp)
                        res.status = bsm_pkg::ST_BAD_OPERAND;
                    else if (sp >= bsm_pkg::STACK_DEPTH_DEF)
                        res.status = bsm_pkg::ST_OVERFLOW;
                    else
                    begin
                        shadow_stack[sp] = shadow_stack[sp-int'(opd)-1];
                        shadow_sp        = sp + 1;
                    end
                end
                bsm_pkg::OP_POP:
                begin
                    if (sp < 1)
                        res.status = bsm_pkg::ST_UNDERFLOW;
                    else
                        shadow_sp = sp - 1;
                end
                bsm_pkg::OP_HALT:
                begin
                    shadow_halted = 1'b1;
                end
                bsm_pkg::OP_WRITE:
                begin
                    if (sp < 1)
                        res.status = bsm_pkg::ST_UNDERFLOW;
                    else
                    begin
                        res.char_valid = 1'b1;
                        res.char_out   = shadow_stack[sp-1];
                    end
                end
                bsm_pkg::OP_SWAP:
                begin
                    if (sp == 0 || int'(opd) >= sp)
                        res.status = bsm_pkg::ST_BAD_OPERAND;
                    else
                    begin
                        tmp                           = shadow_stack[sp-1];
                        shadow_stack[sp-1]            = shadow_stack[sp-1-int'(opd)];
                        shadow_stack[sp-1-int'(opd)]  = tmp;
                    end
                end
                default:
                begin
                    res.status = bsm_pkg::ST_BAD_OPCODE;
                end
            endcase
        end
        // ip advances and wraps unless the step failed or jumped
        if (res.status == bsm_pkg::ST_OK && !jumped)
            shadow_ip = shadow_ip + 8'd1;
        res.next_ip     = shadow_ip;
        res.is_halted   = shadow_halted;
        res.stack_depth = bsm_pkg::DEPTH_W'(shadow_sp);
        return res;
    endfunction

    function automatic string fmt_outcome(input outcome_t o);
        return $sformatf("st=%0d ip=%0d halted=%0d cv=%0d ch=%0d depth=%0d",
                         o.status, o.next_ip, o.is_halted, o.char_valid,
                         o.char_out, o.stack_depth);
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // drive one instruction and hold it until the core takes it
    task automatic issue_instr(input  logic [bsm_pkg::ACTION_W-1:0]  act,
                               input  logic [bsm_pkg::OPERAND_W-1:0] opd,
                               output outcome_t                      pred);
        @(negedge clk);
        start   <= 1'b1;
        action  <= act;
        operand <= opd;
        do
            @(posedge clk);
        while (busy);
        pred = execute_instr(act, opd);
    endtask

    // random instruction, mostly well-formed for the current shadow state
    task automatic pick_random_instr(input  bit                            fill,
                                     output logic [bsm_pkg::ACTION_W-1:0]  act,
                                     output logic [bsm_pkg::OPERAND_W-1:0] opd);
        int roll;
        int push_pct;
        int dup_pct;
        roll     = $urandom_range(0, 99);
        push_pct = fill ? 70 : 28;
        dup_pct  = fill ? 10 : 8;
        if (roll < 3)
            act = bsm_pkg::ACTION_W'($urandom_range(OP_ILLEGAL_LO, OP_ILLEGAL_HI));
        else if (roll < 3 + push_pct)
            act = bsm_pkg::OP_PUSH;
        else if (roll < 3 + push_pct + dup_pct)
            act = bsm_pkg::OP_DUP;
        else
        begin
            case ($urandom_range(0, 9))
                0:       act = bsm_pkg::OP_ADD;
                1:       act = bsm_pkg::OP_SUB;
                2:       act = bsm_pkg::OP_GT;
                3:       act = bsm_pkg::OP_LT;
                4:       act = bsm_pkg::OP_JMP;
                5:       act = bsm_pkg::OP_JNZ;
                6:       act = bsm_pkg::OP_JZ;
                7:       act = bsm_pkg::OP_POP;
                8:       act = bsm_pkg::OP_WRITE;
                default: act = bsm_pkg::OP_SWAP;
            endcase
        end
        opd = bsm_pkg::OPERAND_W'($urandom_range(0, 255));
        // stack depth operands mostly in range
        if ((act == bsm_pkg::OP_DUP || act == bsm_pkg::OP_SWAP) && shadow_sp > 0
            && $urandom_range(0, 9) < 8)
            opd = bsm_pkg::OPERAND_W'($urandom_range(0, shadow_sp - 1));
        // jump targets mostly inside the program
        if ((act == bsm_pkg::OP_JMP || act == bsm_pkg::OP_JNZ || act == bsm_pkg::OP_JZ)
            && shadow_plen != '0 && $urandom_range(0, 9) < 8)
            opd = bsm_pkg::OPERAND_W'($urandom_range(0, int'(shadow_plen) - 1));
    endtask

    // write program_length once nothing is in flight
    task automatic write_plen(input logic [bsm_pkg::PLEN_W-1:0] value);
        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_plen = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            seen_outcome = '{status, next_ip, is_halted, char_valid, char_out, stack_depth};
            if (pending_outcomes.size() == 0)
                flag_error({"result with no pending transaction: ", fmt_outcome(seen_outcome)});
            else
            begin
                due_outcome = pending_outcomes.pop_front();
                if (seen_outcome !== due_outcome)
                    flag_error({"mismatch: expected ", fmt_outcome(due_outcome),
                                " got ", fmt_outcome(seen_outcome)});
            end
        end
    end

    // stimulus
    initial
    begin
        logic [bsm_pkg::PLEN_W-1:0]    phase_plen [NUM_PHASES];
        logic [bsm_pkg::ACTION_W-1:0]  act;
        logic [bsm_pkg::OPERAND_W-1:0] opd;
        outcome_t                      pred;
        int                            idle_pct;

        rst_n     = 1'b0;
        start     = 1'b0;
        action    = '0;
        operand   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        foreach (shadow_stack[i])
            shadow_stack[i] = '0;

        phase_plen = '{9'd0, 9'd1, 9'd255, 9'd256,
                       bsm_pkg::PLEN_W'($urandom_range(2, 256)),
                       9'd128, bsm_pkg::PLEN_W'($urandom_range(2, 256)), 9'd256};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed program from reset state
        write_plen(9'd200);
        foreach (directed_prog[i])
        begin
            issue_instr(directed_prog[i].act, directed_prog[i].opd, pred);
            pending_outcomes.push_back(directed_prog[i].typed ? directed_prog[i].exp : pred);
        end

        // random phases over program lengths and sender idling
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_plen(phase_plen[ph]);
            case (ph % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 83;
                default: idle_pct = 28;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // each cycle is idle with the phase's probability
                while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                begin
                    @(negedge clk);
                    start <= 1'b0;
                end
                pick_random_instr(ph % 2 == 1, act, opd);
                issue_instr(act, opd, pred);
                pending_outcomes.push_back(pred);
            end
        end

        // halt, then everything after it is ignored
        issue_instr(bsm_pkg::OP_HALT, bsm_pkg::OPERAND_W'($urandom_range(0, 255)), pred);
        pending_outcomes.push_back(pred);
        repeat (4)
        begin
            pick_random_instr(1'b0, act, opd);
            issue_instr(act, opd, pred);
            pending_outcomes.push_back(pred);
        end

        // drain and watch for stray results
        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("[byte_stack_machine_execute_core] OK");
        else
            $display("[byte_stack_machine_execute_core] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("[byte_stack_machine_execute_core] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/bsm_pkg.sv
design/bsm_ram.sv
design/bsm_exec.sv
design/byte_stack_machine_execute_core.sv
tb/tb.sv
